// File: design/llk_pkg.sv
// Shared types, constants and the exp fraction table of the logit likelihood block.
`timescale 1ns / 1ps
`default_nettype none
package llk_pkg;

   localparam int ATTR_W = 16;
   localparam int COEF_W = 16;
   localparam int PROD_W = ATTR_W + COEF_W;
   localparam int UTIL_W = 32;
   localparam int ACC_W  = 40;
   localparam int OUT_W  = 32;
   localparam int LN_W   = 21;
   localparam int NUM_LANES_MAX = 4;

   localparam int NUM_REGS = 5;
   localparam int ADDR_W   = 5;
   localparam int REG_IDX_W = ADDR_W - 2;

   localparam logic [REG_IDX_W-1:0] REG_COEF_0   = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_COEF_1   = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_COEF_2   = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_COEF_3   = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_LOG_MODE = 3'd4;

   localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
   localparam logic [31:0] LN2_Q32   = 32'd2977044472;
   localparam logic [32:0] ONE_Q32   = 33'h1_0000_0000;
   localparam logic signed [40:0] ONE_Q16 = 41'sd65536;

   typedef logic [31:0] tab_type [17];

   function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
      logic [63:0] v;
      logic [63:0] r;
      logic [63:0] b;
      v = v_in;
      r = 64'd0;
      b = 64'h4000_0000_0000_0000;
      for (int j = 0; j < 32; j++) begin
         if (b > v) begin
            b = b >> 2;
         end
      end
      for (int j = 0; j < 32; j++) begin
         if (b != 64'd0) begin
            if (v >= r + b) begin
               v = v - (r + b);
               r = (r >> 1) + b;
            end else begin
               r = r >> 1;
            end
            b = b >> 2;
         end
      end
      return r;
   endfunction

   // Entry i > 0 holds 2^32 * 2^(-2^-i), built by repeated floor square roots.
   function automatic tab_type build_tab();
      tab_type t;
      logic [63:0] root;
      t[0] = 32'd0;
      root = isqrt64(64'h8000_0000_0000_0000);
      t[1] = root[31:0];
      for (int i = 2; i <= 16; i++) begin
         root = isqrt64({t[i-1], 32'd0});
         t[i] = root[31:0];
      end
      return t;
   endfunction

   localparam tab_type FRAC_TAB = build_tab();

endpackage
`default_nettype wire

// File: design/llk_if.sv
// Request and response channel interfaces of the logit likelihood block.
`timescale 1ns / 1ps
`default_nettype none
interface llk_req_if;
   import llk_pkg::*;
   logic                     valid;
   logic                     ready;
   logic signed [ATTR_W-1:0] attr_0;
   logic signed [ATTR_W-1:0] attr_1;
   logic signed [ATTR_W-1:0] attr_2;
   logic signed [ATTR_W-1:0] attr_3;
   logic                     is_chosen;
   logic                     last_of_task;
   logic                     last_of_set;
   modport source (output valid, attr_0, attr_1, attr_2, attr_3, is_chosen,
                   last_of_task, last_of_set, input ready);
   modport sink (input valid, attr_0, attr_1, attr_2, attr_3, is_chosen,
                 last_of_task, last_of_set, output ready);
endinterface

interface llk_rsp_if;
   import llk_pkg::*;
   logic                    valid;
   logic                    ready;
   logic signed [OUT_W-1:0] log_likelihood;
   logic [OUT_W-1:0]        probability;
   logic                    error_flag;
   modport source (output valid, log_likelihood, probability, error_flag, input ready);
   modport sink (input valid, log_likelihood, probability, error_flag, output ready);
endinterface
`default_nettype wire

// File: design/logit_choice_likelihood.sv
// Top level of the streaming multinomial logit log-likelihood block.
//
// Each request carries one alternative of a choice task. The attribute lanes
// multiply the attributes by the coefficient registers at the accepting edge
// and a merging stage sums the lane products into a Q16.16 utility in the
// following cycle, so the next request is taken only after the merge. At
// the end of a task a sequencer walks the buffered utilities once for the
// maximum, then once more through the iterative exp unit for the sum of
// exponentials, takes the natural log with 16 squaring steps, forms the
// chosen probability with a 32-step restoring division, skipped when the
// probability is one, and folds it into the product accumulator. The exp
// unit handles one fraction bit per cycle. At the end of a set one response
// is produced: the log-likelihood plus one in Q16.16 when log_mode is set, or
// the product of probabilities in Q0.32 otherwise, with error_flag marking a
// task without a chosen alternative, too many alternatives or saturation.
// The response sits in an output register, so new requests are taken while a
// response waits; only a second set end waits for the slot to free up.
// Configuration must be written through the APB-style port while the block is
// idle; the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
module logit_choice_likelihood #(
   parameter int MAX_ALTERNATIVES = 8,
   parameter int NUM_ATTRS        = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   llk_req_if.sink                     req_bus,
   llk_rsp_if.source                   rsp_bus,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [llk_pkg::ADDR_W-1:0]  paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);
   import llk_pkg::*;

   localparam int CNT_W = $clog2(MAX_ALTERNATIVES + 1);
   localparam int IDX_W = $clog2(MAX_ALTERNATIVES);
   localparam int SUM_W = 33 + $clog2(MAX_ALTERNATIVES);
   localparam int N_STEPS = SUM_W - 33;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_ALTERNATIVES);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_MERGE    = 4'd1;
   localparam logic [3:0] S_MAX      = 4'd2;
   localparam logic [3:0] S_EXP      = 4'd3;
   localparam logic [3:0] S_EXP_WAIT = 4'd4;
   localparam logic [3:0] S_LN_INIT  = 4'd5;
   localparam logic [3:0] S_LN_SQ    = 4'd6;
   localparam logic [3:0] S_LN_MUL   = 4'd7;
   localparam logic [3:0] S_ACC      = 4'd8;
   localparam logic [3:0] S_EC       = 4'd9;
   localparam logic [3:0] S_EC_WAIT  = 4'd10;
   localparam logic [3:0] S_DIV      = 4'd11;
   localparam logic [3:0] S_PROD     = 4'd12;
   localparam logic [3:0] S_TASK_END = 4'd13;
   localparam logic [3:0] S_EMIT     = 4'd14;

   localparam logic signed [41:0] ACC_HI = (42'sd1 <<< 39) - 42'sd1;
   localparam logic signed [41:0] ACC_LO = -(42'sd1 <<< 39);
   localparam logic signed [40:0] LL_HI  = 41'sd2147483647;
   localparam logic signed [40:0] LL_LO  = -41'sd2147483648;

   // Configuration registers.
   logic signed [COEF_W-1:0] coef_ff [NUM_LANES_MAX];
   logic                     log_mode_ff;
   logic                     csr_write;
   logic [REG_IDX_W-1:0]     csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[ADDR_W-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_LANES_MAX; i++) begin
            coef_ff[i] <= '0;
         end
         log_mode_ff <= 1'b1;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_COEF_0:   coef_ff[0]  <= pwdata[COEF_W-1:0];
            REG_COEF_1:   coef_ff[1]  <= pwdata[COEF_W-1:0];
            REG_COEF_2:   coef_ff[2]  <= pwdata[COEF_W-1:0];
            REG_COEF_3:   coef_ff[3]  <= pwdata[COEF_W-1:0];
            REG_LOG_MODE: log_mode_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_COEF_0:   prdata = 32'(coef_ff[0]);
         REG_COEF_1:   prdata = 32'(coef_ff[1]);
         REG_COEF_2:   prdata = 32'(coef_ff[2]);
         REG_COEF_3:   prdata = 32'(coef_ff[3]);
         REG_LOG_MODE: prdata = {31'd0, log_mode_ff};
         default:      prdata = 32'd0;
      endcase
   end

   // Sequencer state and the per-task and per-set accumulators.
   logic [3:0]               state_ff, state_in;
   logic                     chosen_flag_ff, task_flag_ff, set_flag_ff;
   logic [CNT_W-1:0]         alt_count_ff, alt_count_in;
   logic [IDX_W-1:0]         idx_ff, idx_in;
   logic signed [UTIL_W-1:0] chosen_util_ff, chosen_util_in;
   logic                     chosen_seen_ff, chosen_seen_in;
   logic signed [ACC_W-1:0]  log_acc_ff, log_acc_in;
   logic                     error_ff, error_in;
   logic [32:0]              prob_acc_ff, prob_acc_in;
   logic signed [UTIL_W-1:0] max_ff, max_in;
   logic [SUM_W-1:0]         sum_ff, sum_in;
   logic [4:0]               n_ff, n_in;
   logic [31:0]              z_ff, z_in;
   logic [15:0]              bits_ff, bits_in;
   logic [4:0]               step_ff, step_in;
   logic [LN_W-1:0]          ln_ff, ln_in;
   logic [SUM_W-1:0]         rem_ff, rem_in;
   logic [31:0]              p_ff, p_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_W-1:0]  rsp_ll_ff, rsp_ll_in;
   logic [OUT_W-1:0]         rsp_prob_ff, rsp_prob_in;
   logic                     rsp_err_ff, rsp_err_in;

   logic signed [UTIL_W-1:0] util_buf [MAX_ALTERNATIVES];
   logic                     buf_write;

   logic                     accept;
   logic signed [ATTR_W-1:0] attr_arr [NUM_LANES_MAX];
   logic signed [PROD_W-1:0] prod [NUM_ATTRS];
   logic signed [PROD_W+1:0] util_sum;
   logic signed [PROD_W+1:0] util_shift;
   logic signed [UTIL_W-1:0] util;
   logic signed [UTIL_W-1:0] buf_rd;
   logic [CNT_W-1:0]         idx_next;
   logic                     idx_last;

   logic                     exp_start;
   logic [32:0]              exp_x;
   logic                     exp_done;
   logic [32:0]              exp_result;

   logic [4:0]               n_calc;
   logic [SUM_W-1:0]         s_shift;
   logic [63:0]              z_sq;
   logic [32:0]              z_next;
   logic [52:0]              ln_prod;
   logic signed [41:0]       lp_sum;
   logic [SUM_W:0]           rem_dbl;
   logic [63:0]              prod_mul;
   logic signed [40:0]       ll_full;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign accept        = req_bus.valid && req_bus.ready;

   assign attr_arr[0] = req_bus.attr_0;
   assign attr_arr[1] = req_bus.attr_1;
   assign attr_arr[2] = req_bus.attr_2;
   assign attr_arr[3] = req_bus.attr_3;

   // Attribute lanes, loaded at the accepting edge.
   for (genvar g = 0; g < NUM_ATTRS; g++) begin : g_lane
      llk_lane u_lane (
         .clock   (clock),
         .load    (accept),
         .attr    (attr_arr[g]),
         .coef    (coef_ff[g]),
         .product (prod[g])
      );
   end

   // Merging stage: sum the lanes and drop to Q16.16 with a floor shift.
   always_comb begin
      util_sum = '0;
      for (int i = 0; i < NUM_ATTRS; i++) begin
         util_sum = util_sum + (PROD_W+2)'(prod[i]);
      end
   end
   assign util_shift = util_sum >>> 6;
   assign util       = util_shift[UTIL_W-1:0];

   assign buf_rd   = util_buf[idx_ff];
   assign idx_next = CNT_W'(idx_ff) + CNT_W'(1);
   assign idx_last = (idx_next >= alt_count_ff);

   assign buf_write = (state_ff == S_MERGE) && (alt_count_ff < MAX_CNT);

   always_ff @(posedge clock) begin
      if (buf_write) begin
         util_buf[alt_count_ff[IDX_W-1:0]] <= util;
      end
   end

   assign exp_start = (state_ff == S_EXP) || (state_ff == S_EC);
   assign exp_x     = (state_ff == S_EC) ? 33'(34'(max_ff) - 34'(chosen_util_ff))
                                         : 33'(34'(max_ff) - 34'(buf_rd));

   llk_exp u_exp (
      .clock  (clock),
      .reset  (reset),
      .start  (exp_start),
      .x      (exp_x),
      .done   (exp_done),
      .result (exp_result)
   );

   // Integer part of log2 of the exp sum, above one.
   always_comb begin
      n_calc = 5'd0;
      for (int j = 0; j < N_STEPS; j++) begin
         if (n_calc == 5'(j) && (sum_ff >> (33 + j)) != '0) begin
            n_calc = 5'(j + 1);
         end
      end
   end
   assign s_shift = sum_ff >> n_calc;

   assign z_sq     = z_ff * z_ff;
   assign z_next   = z_sq[63:31];
   assign ln_prod  = {n_ff, bits_ff} * LN2_Q32;
   assign lp_sum   = 42'(log_acc_ff) + 42'(chosen_util_ff) - 42'(max_ff)
                     - 42'(signed'({1'b0, ln_ff}));
   assign rem_dbl  = {rem_ff, 1'b0};
   assign prod_mul = prob_acc_ff[31:0] * p_ff;
   assign ll_full  = 41'(log_acc_ff) + ONE_Q16;

   always_comb begin
      state_in       = state_ff;
      alt_count_in   = alt_count_ff;
      idx_in         = idx_ff;
      chosen_util_in = chosen_util_ff;
      chosen_seen_in = chosen_seen_ff;
      log_acc_in     = log_acc_ff;
      error_in       = error_ff;
      prob_acc_in    = prob_acc_ff;
      max_in         = max_ff;
      sum_in         = sum_ff;
      n_in           = n_ff;
      z_in           = z_ff;
      bits_in        = bits_ff;
      step_in        = step_ff;
      ln_in          = ln_ff;
      rem_in         = rem_ff;
      p_in           = p_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_bus.ready;
      rsp_ll_in      = rsp_ll_ff;
      rsp_prob_in    = rsp_prob_ff;
      rsp_err_in     = rsp_err_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_MERGE;
            end
         end
         S_MERGE: begin
            if (alt_count_ff < MAX_CNT) begin
               alt_count_in = alt_count_ff + CNT_W'(1);
               if (chosen_flag_ff) begin
                  chosen_util_in = util;
                  chosen_seen_in = 1'b1;
               end
            end else begin
               // Alternatives beyond the buffer depth are dropped.
               error_in = 1'b1;
            end
            idx_in = '0;
            if (task_flag_ff || set_flag_ff) begin
               state_in = S_MAX;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_MAX: begin
            if (idx_ff == '0 || buf_rd > max_ff) begin
               max_in = buf_rd;
            end
            if (idx_last) begin
               idx_in   = '0;
               sum_in   = '0;
               state_in = S_EXP;
            end else begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         S_EXP: begin
            state_in = S_EXP_WAIT;
         end
         S_EXP_WAIT: begin
            if (exp_done) begin
               sum_in = sum_ff + SUM_W'(exp_result);
               if (idx_last) begin
                  if (chosen_seen_ff) begin
                     state_in = S_LN_INIT;
                  end else begin
                     error_in = 1'b1;
                     state_in = S_TASK_END;
                  end
               end else begin
                  idx_in   = idx_ff + IDX_W'(1);
                  state_in = S_EXP;
               end
            end
         end
         S_LN_INIT: begin
            n_in     = n_calc;
            z_in     = s_shift[32:1];
            bits_in  = '0;
            step_in  = '0;
            state_in = S_LN_SQ;
         end
         S_LN_SQ: begin
            if (z_next[32]) begin
               z_in    = z_next[32:1];
               bits_in = {bits_ff[14:0], 1'b1};
            end else begin
               z_in    = z_next[31:0];
               bits_in = {bits_ff[14:0], 1'b0};
            end
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd15) begin
               state_in = S_LN_MUL;
            end
         end
         S_LN_MUL: begin
            ln_in    = ln_prod[52:32];
            state_in = S_ACC;
         end
         S_ACC: begin
            if (lp_sum > ACC_HI) begin
               log_acc_in = ACC_HI[ACC_W-1:0];
               error_in   = 1'b1;
            end else if (lp_sum < ACC_LO) begin
               log_acc_in = ACC_LO[ACC_W-1:0];
               error_in   = 1'b1;
            end else begin
               log_acc_in = lp_sum[ACC_W-1:0];
            end
            state_in = S_EC;
         end
         S_EC: begin
            state_in = S_EC_WAIT;
         end
         S_EC_WAIT: begin
            if (exp_done) begin
               if (SUM_W'(exp_result) >= sum_ff) begin
                  // Probability of one leaves the product unchanged.
                  state_in = S_TASK_END;
               end else begin
                  rem_in   = SUM_W'(exp_result);
                  p_in     = '0;
                  step_in  = '0;
                  state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (rem_dbl >= (SUM_W+1)'(sum_ff)) begin
               rem_in = SUM_W'(rem_dbl - (SUM_W+1)'(sum_ff));
               p_in   = {p_ff[30:0], 1'b1};
            end else begin
               rem_in = rem_dbl[SUM_W-1:0];
               p_in   = {p_ff[30:0], 1'b0};
            end
            step_in = step_ff + 5'd1;
            if (step_ff == 5'd31) begin
               state_in = S_PROD;
            end
         end
         S_PROD: begin
            prob_acc_in = prob_acc_ff[32] ? {1'b0, p_ff} : {1'b0, prod_mul[63:32]};
            state_in    = S_TASK_END;
         end
         S_TASK_END: begin
            chosen_seen_in = 1'b0;
            alt_count_in   = '0;
            state_in       = set_flag_ff ? S_EMIT : S_IDLE;
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in = 1'b1;
               rsp_err_in   = error_ff;
               if (log_mode_ff) begin
                  rsp_prob_in = '0;
                  if (ll_full > LL_HI) begin
                     rsp_ll_in  = LL_HI[OUT_W-1:0];
                     rsp_err_in = 1'b1;
                  end else if (ll_full < LL_LO) begin
                     rsp_ll_in  = LL_LO[OUT_W-1:0];
                     rsp_err_in = 1'b1;
                  end else begin
                     rsp_ll_in = ll_full[OUT_W-1:0];
                  end
               end else begin
                  rsp_ll_in   = '0;
                  rsp_prob_in = prob_acc_ff[32] ? '1 : prob_acc_ff[31:0];
               end
               log_acc_in     = '0;
               prob_acc_in    = ONE_Q32;
               error_in       = 1'b0;
               chosen_seen_in = 1'b0;
               alt_count_in   = '0;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         alt_count_ff   <= '0;
         chosen_util_ff <= '0;
         chosen_seen_ff <= 1'b0;
         log_acc_ff     <= '0;
         error_ff       <= 1'b0;
         prob_acc_ff    <= ONE_Q32;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         alt_count_ff   <= alt_count_in;
         chosen_util_ff <= chosen_util_in;
         chosen_seen_ff <= chosen_seen_in;
         log_acc_ff     <= log_acc_in;
         error_ff       <= error_in;
         prob_acc_ff    <= prob_acc_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         chosen_flag_ff <= req_bus.is_chosen;
         task_flag_ff   <= req_bus.last_of_task;
         set_flag_ff    <= req_bus.last_of_set;
      end
      idx_ff      <= idx_in;
      max_ff      <= max_in;
      sum_ff      <= sum_in;
      n_ff        <= n_in;
      z_ff        <= z_in;
      bits_ff     <= bits_in;
      step_ff     <= step_in;
      ln_ff       <= ln_in;
      rem_ff      <= rem_in;
      p_ff        <= p_in;
      rsp_ll_ff   <= rsp_ll_in;
      rsp_prob_ff <= rsp_prob_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.log_likelihood = rsp_ll_ff;
   assign rsp_bus.probability    = rsp_prob_ff;
   assign rsp_bus.error_flag     = rsp_err_ff;
endmodule
`default_nettype wire

// File: design/llk_lane.sv
// One dot-product lane: attribute times coefficient, registered.
`timescale 1ns / 1ps
`default_nettype none
module llk_lane (
   input  logic                             clock,
   input  logic                             load,
   input  logic signed [llk_pkg::ATTR_W-1:0] attr,
   input  logic signed [llk_pkg::COEF_W-1:0] coef,
   output logic signed [llk_pkg::PROD_W-1:0] product
);
   import llk_pkg::*;

   logic signed [PROD_W-1:0] product_ff;

   always_ff @(posedge clock) begin
      if (load) begin
         product_ff <= attr * coef;
      end
   end

   assign product = product_ff;
endmodule
`default_nettype wire

// File: design/llk_exp.sv
// Iterative exp(-x) unit, Q17.16 in and Q1.32 out, one fraction bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module llk_exp (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [32:0] x,
   output logic        done,
   output logic [32:0] result
);
   import llk_pkg::*;

   localparam logic [1:0] ES_IDLE = 2'd0;
   localparam logic [1:0] ES_MUL  = 2'd1;
   localparam logic [1:0] ES_ITER = 2'd2;
   localparam logic [1:0] ES_FIN  = 2'd3;

   logic [1:0]  st_ff, st_in;
   logic [32:0] x_ff;
   logic        big_ff;
   logic [60:0] y_ff;
   logic [32:0] r_ff, r_in;
   logic [4:0]  i_ff;
   logic [32:0] result_ff;
   logic        done_ff;

   logic [15:0] g;
   logic [3:0]  g_pos;
   logic [63:0] r_prod;
   logic [14:0] k;

   assign g      = y_ff[45:30];
   assign g_pos  = 4'(5'd16 - i_ff);
   assign r_prod = r_ff[31:0] * FRAC_TAB[i_ff];
   assign k      = y_ff[60:46];

   always_comb begin
      st_in = st_ff;
      r_in  = r_ff;
      unique case (st_ff)
         ES_IDLE: begin
            if (start) begin
               st_in = ES_MUL;
            end
         end
         ES_MUL: begin
            st_in = ES_ITER;
            r_in  = ONE_Q32;
         end
         ES_ITER: begin
            if (g[g_pos]) begin
               r_in = r_ff[32] ? {1'b0, FRAC_TAB[i_ff]} : {1'b0, r_prod[63:32]};
            end
            if (i_ff == 5'd16) begin
               st_in = ES_FIN;
            end
         end
         ES_FIN: begin
            st_in = ES_IDLE;
         end
         default: begin
            st_in = ES_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= ES_IDLE;
         done_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         done_ff <= (st_ff == ES_FIN);
      end
   end

   always_ff @(posedge clock) begin
      r_ff <= r_in;
      if (st_ff == ES_IDLE && start) begin
         x_ff <= x;
      end
      if (st_ff == ES_MUL) begin
         y_ff   <= x_ff[29:0] * LOG2E_Q30;
         big_ff <= (x_ff[32:30] != 3'd0);
         i_ff   <= 5'd1;
      end
      if (st_ff == ES_ITER) begin
         i_ff <= i_ff + 5'd1;
      end
      if (st_ff == ES_FIN) begin
         result_ff <= (big_ff || k >= 15'd33) ? 33'd0 : (r_ff >> k[5:0]);
      end
   end

   assign done   = done_ff;
   assign result = result_ff;
endmodule
`default_nettype wire

// File: design/llk_checker.sv
// Port-level checks of the logit likelihood block and their binding.
`timescale 1ns / 1ps
`default_nettype none
module llk_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_ll,
   input logic [31:0] rsp_prob,
   input logic        pready
);
   // A response waiting for the consumer stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response withdrawn before it was taken");

   a_pready: assert property (@(posedge clock) disable iff (reset) pready)
      else $error("configuration port not ready");

   // A set end always needs the task walk, so no response follows a request at once.
   a_no_fast_rsp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_valid && req_ready))
      else $error("response one cycle after a request");

   // Only one of the two result fields carries a value.
   a_one_field: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_ll == 32'd0 || rsp_prob == 32'd0))
      else $error("both result fields are non-zero");
endmodule

bind logit_choice_likelihood llk_checker u_llk_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_ll    (rsp_bus.log_likelihood),
   .rsp_prob  (rsp_bus.probability),
   .pready    (pready)
);
`default_nettype wire
